@@ src/dgf_pkg.sv @@
// ----------------------------------------------------------------------------
// dgf_pkg: shared types and constants of the grouped decimal formatter
// Holds the controller state type, the command and status bundles, the
// character codes and the small decode functions used by several files.
// ----------------------------------------------------------------------------
package dgf_pkg;

    localparam int VALUE_W  = 64;
    localparam int MODE_W   = 2;
    localparam int NDIGITS  = 20;
    localparam int DIGIT_W  = 4;
    localparam int BCD_W    = NDIGITS * DIGIT_W;
    localparam int CHAR_W   = 8;
    localparam int COL_W    = 5;   // holds field widths up to 27
    localparam int BITCNT_W = 7;   // holds operand sizes up to 64

    localparam logic [MODE_W-1:0] MODE_8  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_16 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_32 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_64 = 2'd3;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_32;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_COMMA   = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_EMIT
    } dgf_state_t;

    typedef struct packed {
        logic load;    // take a new operand
        logic shift;   // one shift-and-add step
        logic size;    // latch the text length
        logic emit;    // load the next character into the output register
    } dgf_cmd_t;

    typedef struct packed {
        logic conv_last;  // the current shift step is the final one
        logic rem_zero;   // the next character is the newline
        logic out_free;   // the output register can take a character
    } dgf_stat_t;

    function automatic logic [COL_W-1:0] field_width(input logic [MODE_W-1:0] mode);
        logic [COL_W-1:0] w;
        unique case (mode)
            MODE_8:  w = 5'd4;
            MODE_16: w = 5'd6;
            MODE_32: w = 5'd14;
            MODE_64: w = 5'd27;
            default: w = 5'd27;
        endcase
        return w;
    endfunction

    function automatic logic [BITCNT_W-1:0] operand_bits(input logic [MODE_W-1:0] mode);
        logic [BITCNT_W-1:0] b;
        unique case (mode)
            MODE_8:  b = 7'd8;
            MODE_16: b = 7'd16;
            MODE_32: b = 7'd32;
            MODE_64: b = 7'd64;
            default: b = 7'd64;
        endcase
        return b;
    endfunction

    // digits plus one comma per group of three, full or partial, above the lowest group
    function automatic logic [COL_W-1:0] text_length(input logic [COL_W-1:0] ndig);
        logic [COL_W-1:0] commas;
        if (ndig > 5'd18)      commas = 5'd6;
        else if (ndig > 5'd15) commas = 5'd5;
        else if (ndig > 5'd12) commas = 5'd4;
        else if (ndig > 5'd9)  commas = 5'd3;
        else if (ndig > 5'd6)  commas = 5'd2;
        else if (ndig > 5'd3)  commas = 5'd1;
        else                   commas = 5'd0;
        return ndig + commas;
    endfunction

endpackage

@@ src/dgf_ctrl.sv @@
// ----------------------------------------------------------------------------
// dgf_ctrl: sequencing controller of the grouped decimal formatter
// Walks each operand through load, binary-to-BCD conversion, text sizing
// and character output, issuing one command bundle per cycle.
// ----------------------------------------------------------------------------
module dgf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  dgf_pkg::dgf_stat_t stat,
    output dgf_pkg::dgf_cmd_t  cmd
);
    import dgf_pkg::*;

    dgf_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.shift = 1'b1;
                if (stat.conv_last) begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE: begin
                cmd.size   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    // the newline closes the run
                    if (stat.rem_zero) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

@@ src/dgf_datapath.sv @@
// ----------------------------------------------------------------------------
// dgf_datapath: conversion and character datapath
// Shift-and-add-3 binary-to-BCD converter, digit count, character select
// and the output register of the result stream.
// ----------------------------------------------------------------------------
module dgf_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [dgf_pkg::MODE_W-1:0]        size_mode,
    input  logic [dgf_pkg::VALUE_W-1:0]       s_tdata,
    input  dgf_pkg::dgf_cmd_t                 cmd,
    output dgf_pkg::dgf_stat_t                stat,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dgf_pkg::CHAR_W-1:0]        m_tdata,
    output logic                              m_tlast
);
    import dgf_pkg::*;

    logic [VALUE_W-1:0]                 bin_reg, bin_next;
    logic [NDIGITS-1:0][DIGIT_W-1:0]    bcd_reg, bcd_next;
    logic [NDIGITS-1:0][DIGIT_W-1:0]    bcd_adj;
    logic [BITCNT_W-1:0]                bitcnt_reg, bitcnt_next;
    logic [COL_W-1:0]                   rem_reg, rem_next;
    logic [COL_W-1:0]                   tlen_reg, tlen_next;
    logic [COL_W-1:0]                   ndig;
    logic [COL_W-1:0]                   col;
    logic [COL_W-1:0]                   grp;
    logic [COL_W-1:0]                   didx;
    logic [DIGIT_W-1:0]                 digit;
    logic [VALUE_W-1:0]                 aligned;
    logic [CHAR_W-1:0]                  char_sel;
    logic [CHAR_W-1:0]                  m_tdata_reg, m_tdata_next;
    logic                               m_tlast_reg, m_tlast_next;
    logic                               m_tvalid_reg, m_tvalid_next;

    // place the operand's top bit at bit 63; bits above the size drop out
    always_comb begin
        case (size_mode)
            MODE_8:  aligned = {s_tdata[7:0],  56'd0};
            MODE_16: aligned = {s_tdata[15:0], 48'd0};
            MODE_32: aligned = {s_tdata[31:0], 32'd0};
            default: aligned = s_tdata;
        endcase
    end

    always_comb begin
        for (int i = 0; i < NDIGITS; i++) begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    // count significant digits, at least one
    always_comb begin
        ndig = 5'd1;
        for (int i = 1; i < NDIGITS; i++) begin
            if (bcd_reg[i] != 4'd0) begin
                ndig = COL_W'(i + 1);
            end
        end
    end

    // column counted from the right; every fourth column is a comma
    assign col  = rem_reg - 5'd1;
    assign grp  = {2'b00, col[4:2]};
    assign didx = (grp << 1) + grp + {3'b000, col[1:0]};

    always_comb begin
        digit = '0;
        for (int i = 0; i < NDIGITS; i++) begin
            if (didx == COL_W'(i)) begin
                digit = bcd_reg[i];
            end
        end
    end

    always_comb begin
        if (rem_reg == 5'd0) begin
            char_sel = CHAR_NEWLINE;
        end else if (col >= tlen_reg) begin
            char_sel = CHAR_SPACE;
        end else if (col[1:0] == 2'd3) begin
            char_sel = CHAR_COMMA;
        end else begin
            char_sel = CHAR_ZERO | {4'd0, digit};
        end
    end

    always_comb begin
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        bitcnt_next = bitcnt_reg;
        rem_next    = rem_reg;
        tlen_next   = tlen_reg;
        if (cmd.load) begin
            bin_next    = aligned;
            bcd_next    = '0;
            bitcnt_next = operand_bits(size_mode);
            rem_next    = field_width(size_mode);
        end
        if (cmd.shift) begin
            {bcd_next, bin_next} = {bcd_adj[NDIGITS-1:0], bin_reg} << 1;
            bitcnt_next          = bitcnt_reg - 7'd1;
        end
        if (cmd.size) begin
            tlen_next = text_length(ndig);
        end
        if (cmd.emit) begin
            rem_next = rem_reg - 5'd1;
        end
    end

    always_comb begin
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit) begin
            m_tdata_next  = char_sel;
            m_tlast_next  = (rem_reg == 5'd0);
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bitcnt_reg   <= '0;
            rem_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            bitcnt_reg   <= bitcnt_next;
            rem_reg      <= rem_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        tlen_reg    <= tlen_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign stat.conv_last = (bitcnt_reg == 7'd1);
    assign stat.rem_zero  = (rem_reg == 5'd0);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ src/decimal_grouped_formatter_top.sv @@
// ----------------------------------------------------------------------------
// decimal_grouped_formatter_top: unsigned integer to grouped decimal text
// Input stream: one 64-bit unsigned value per transaction on s_tdata.
// Output stream: one ASCII character per transaction on m_tdata; the
// right-justified decimal text with commas between groups of three
// digits, padded with spaces to 4, 6, 14 or 27 characters, then a
// newline flagged by m_tlast.
// cfg_we/cfg_wdata set the operand size (0=8, 1=16, 2=32, 3=64 bits),
// which masks the value and picks the field width; write it while idle.
// Sequence: after the input transaction, the shift-and-add-3 converter
// takes one shift step per operand bit (8, 16, 32 or 64), a sizing step
// latches the text length, and the first character is then loaded into
// the output register. Characters leave one per cycle while m_tready is
// high, field width + 1 in all; the next value is taken once the newline
// sits in the output register. A stall on m_tready holds the current
// character and pauses the run. Reset returns to idle with the size set
// to 32 bits and no output valid.
// ----------------------------------------------------------------------------
module decimal_grouped_formatter_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [dgf_pkg::MODE_W-1:0]  cfg_wdata,   // size_mode
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [dgf_pkg::VALUE_W-1:0] s_tdata,     // [63:0] value
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [dgf_pkg::CHAR_W-1:0]  m_tdata,     // [7:0] out_char
    output logic                        m_tlast
);
    import dgf_pkg::*;

    logic [MODE_W-1:0] size_mode_reg, size_mode_next;
    dgf_cmd_t          cmd;
    dgf_stat_t         stat;

    assign size_mode_next = cfg_we ? cfg_wdata : size_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_mode_reg <= MODE_RESET;
        end else begin
            size_mode_reg <= size_mode_next;
        end
    end

    dgf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dgf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .size_mode (size_mode_reg),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // the closing character is always the newline
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == CHAR_NEWLINE)
        else $error("last character is not a newline");

    // a run starts: input ready drops once a value is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again during a run");

    // a character before the newline means the run is still in progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready while a run is still being sent");

endmodule
